>>> hw/rtl/som_ring_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// som_ring_pkg
// Shared constants, types and the Gaussian neighborhood table of the ring map.
// ----------------------------------------------------------------------------
package som_ring_pkg;

   localparam int MAX_NEURONS = 1024;
   localparam int IDX_W       = 10;
   localparam int CNT_W       = 11;
   localparam int COORD_W     = 16;
   localparam int WORD_W      = 2 * COORD_W;
   localparam int SQ_W        = 2 * COORD_W + 1;
   localparam int EXP_DEPTH   = 256;
   localparam int EXP_IDX_W   = 8;
   localparam int EXP_SPAN    = 16;
   localparam int SPAN_SH     = 5;            // 2 * EXP_SPAN as a shift
   localparam int G_W         = 17;
   localparam int LR_W        = 24;
   localparam int RAD_W       = 32;
   localparam int ITER_W      = 32;
   localparam int R_W         = IDX_W;
   localparam int R2_W        = 2 * R_W;
   localparam int D2_W        = 2 * IDX_W;
   localparam int DIV_W       = R2_W + SPAN_SH + EXP_IDX_W;

   localparam logic [31:0] LR_DECAY = 32'd4294838447;
   localparam logic [31:0] N_DECAY  = 32'd4293678806;
   localparam logic [RAD_W-1:0] ONE_Q16 = RAD_W'(65536);
   localparam logic [15:0] REC10    = 16'd52429;   // 2^19 / 10, exact below 2^16
   localparam int          REC10_SH = 19;

   localparam logic [CNT_W-1:0] NEURONS_RST  = CNT_W'(1024);
   localparam logic [LR_W-1:0]  LR_START_RST = LR_W'(13421773);
   localparam logic [ITER_W-1:0] LIMIT_RST   = ITER_W'(100000);

   localparam logic [1:0] CSR_NEURONS = 2'd0;
   localparam logic [1:0] CSR_LR      = 2'd1;
   localparam logic [1:0] CSR_LIMIT   = 2'd2;

   localparam logic ACT_LOAD  = 1'b0;
   localparam logic ACT_TRAIN = 1'b1;

   typedef logic [G_W-1:0] gauss_tab_type [EXP_DEPTH];

   // token handed from cell to cell along the divider chain
   typedef struct packed {
      logic                 vld;
      logic [IDX_W-1:0]     idx;
      logic [COORD_W-1:0]   wx;
      logic [COORD_W-1:0]   wy;
      logic                 over;
      logic [DIV_W-1:0]     rem;
      logic [EXP_IDX_W-1:0] quot;
   } div_tok_type;

   // read issue from the sequencer to a pass unit
   typedef struct packed {
      logic             vld;
      logic [IDX_W-1:0] idx;
      logic [IDX_W-1:0] ring_dist;
   } issue_type;

   // exp(-t) over [0, EXP_SPAN) by repeated multiplication
   function automatic gauss_tab_type build_gauss();
      logic [63:0]   x;
      logic [63:0]   term;
      logic [63:0]   sum;
      logic [63:0]   acc;
      gauss_tab_type t;
      x    = (64'(EXP_SPAN) << 32) / 64'(EXP_DEPTH);
      term = 64'd1 << 32;
      sum  = 64'd1 << 32;
      acc  = 64'd1 << 32;
      for (int k = 1; k <= 20; k++) begin
         term = ((term * x) >> 32) / 64'(k);
         if ((k % 2) == 1) begin
            sum = sum - term;
         end else begin
            sum = sum + term;
         end
      end
      for (int j = 0; j < EXP_DEPTH; j++) begin
         t[j] = G_W'((acc + 64'h8000) >> 16);
         acc  = (acc * sum) >> 32;
      end
      return t;
   endfunction

   localparam gauss_tab_type GAUSS_TAB = build_gauss();

   // saturate the neuron count to the ring limits
   function automatic logic [CNT_W-1:0] ring_size(input logic [CNT_W-1:0] n);
      logic [CNT_W-1:0] r;
      r = n;
      if (n < CNT_W'(2)) begin
         r = CNT_W'(2);
      end else if (n > CNT_W'(MAX_NEURONS)) begin
         r = CNT_W'(MAX_NEURONS);
      end
      return r;
   endfunction

endpackage
`default_nettype wire

>>> hw/rtl/som_ring_wmem.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// som_ring_wmem
// Neuron weight memory, x in the upper half, one write and one registered read.
// ----------------------------------------------------------------------------
module som_ring_wmem
   import som_ring_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [IDX_W-1:0]  wr_addr,
   input  wire logic [WORD_W-1:0] wr_data,
   input  wire logic [IDX_W-1:0]  rd_addr,
   output logic      [WORD_W-1:0] rd_data
);

   logic [WORD_W-1:0] mem [MAX_NEURONS];
   logic [WORD_W-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

>>> hw/rtl/som_ring_srch.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// som_ring_srch
// Winner search: squared distance per neuron and a running minimum.
// ----------------------------------------------------------------------------
module som_ring_srch
   import som_ring_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               clear,
   input  wire issue_type          issue,
   input  wire logic [WORD_W-1:0]  rd_data,
   input  wire logic [COORD_W-1:0] px,
   input  wire logic [COORD_W-1:0] py,
   output logic      [IDX_W-1:0]   winner,
   output logic                    busy
);

   logic                   vld1_ff, vld2_ff, first_ff;
   logic [IDX_W-1:0]       idx1_ff, idx2_ff, win_ff;
   logic [2*COORD_W-1:0]   sqx_ff, sqy_ff;
   logic [SQ_W-1:0]        best_ff;
   logic [COORD_W-1:0]     wx, wy, dx, dy;
   logic [SQ_W-1:0]        sum;

   assign wx  = rd_data[WORD_W-1:COORD_W];
   assign wy  = rd_data[COORD_W-1:0];
   assign dx  = (px >= wx) ? px - wx : wx - px;
   assign dy  = (py >= wy) ? py - wy : wy - py;
   assign sum = SQ_W'(sqx_ff) + SQ_W'(sqy_ff);

   // align the tag with the read data, then square
   always_ff @(posedge clock) begin
      if (reset) begin
         vld1_ff <= 1'b0;
         vld2_ff <= 1'b0;
      end else begin
         vld1_ff <= issue.vld;
         vld2_ff <= vld1_ff;
      end
      idx1_ff <= issue.idx;
      idx2_ff <= idx1_ff;
      sqx_ff  <= dx * dx;
      sqy_ff  <= dy * dy;
   end

   // keep the least distance, lowest index on a tie
   always_ff @(posedge clock) begin
      if (reset) begin
         first_ff <= 1'b1;
      end else if (clear) begin
         first_ff <= 1'b1;
      end else if (vld2_ff && (first_ff || sum < best_ff)) begin
         first_ff <= 1'b0;
      end
      if (vld2_ff && (first_ff || sum < best_ff)) begin
         best_ff <= sum;
         win_ff  <= idx2_ff;
      end
   end

   assign winner = win_ff;
   assign busy   = vld1_ff | vld2_ff;

endmodule
`default_nettype wire

>>> hw/rtl/som_ring_div_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// som_ring_div_cell
// One restoring-division cell: settles one quotient bit, hands on the token.
// ----------------------------------------------------------------------------
module som_ring_div_cell
   import som_ring_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic [DIV_W-1:0] div_shift,
   input  wire div_tok_type      tok_in,
   output div_tok_type           tok_out
);

   div_tok_type tok_ff, tok_in_nxt;
   logic        ge;

   assign ge = tok_in.rem >= div_shift;

   // subtract when it fits and shift the bit in
   always_comb begin
      tok_in_nxt      = tok_in;
      tok_in_nxt.rem  = ge ? tok_in.rem - div_shift : tok_in.rem;
      tok_in_nxt.quot = {tok_in.quot[EXP_IDX_W-2:0], ge};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff.vld <= 1'b0;
      end else begin
         tok_ff.vld <= tok_in.vld;
      end
      tok_ff.idx  <= tok_in_nxt.idx;
      tok_ff.wx   <= tok_in_nxt.wx;
      tok_ff.wy   <= tok_in_nxt.wy;
      tok_ff.over <= tok_in_nxt.over;
      tok_ff.rem  <= tok_in_nxt.rem;
      tok_ff.quot <= tok_in_nxt.quot;
   end

   assign tok_out = tok_ff;

endmodule
`default_nettype wire

>>> hw/rtl/som_ring_upd.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// som_ring_upd
// Weight update pipeline: ring distance to table index through a chain of
// division cells, Gaussian gain, step toward the point, write back.
// ----------------------------------------------------------------------------
module som_ring_upd
   import som_ring_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire issue_type          issue,
   input  wire logic [WORD_W-1:0]  rd_data,
   input  wire logic [R2_W-1:0]    r2,
   input  wire logic [LR_W-1:0]    lr,
   input  wire logic [COORD_W-1:0] px,
   input  wire logic [COORD_W-1:0] py,
   output logic                    wr_en,
   output logic      [IDX_W-1:0]   wr_addr,
   output logic      [WORD_W-1:0]  wr_data,
   output logic                    busy
);

   localparam int GLP_W  = G_W + LR_W;
   localparam int STP_W  = LR_W + COORD_W + 1;

   // stage registers
   logic                 a_vld_ff, b_vld_ff, e_vld_ff, f_vld_ff, g_vld_ff, wr_en_ff;
   logic [IDX_W-1:0]     a_idx_ff, b_idx_ff, e_idx_ff, f_idx_ff, g_idx_ff, wr_addr_ff;
   logic [IDX_W-1:0]     a_dist_ff;
   logic [COORD_W-1:0]   b_wx_ff, b_wy_ff, e_wx_ff, e_wy_ff;
   logic [COORD_W-1:0]   f_wx_ff, f_wy_ff, g_wx_ff, g_wy_ff;
   logic [D2_W-1:0]      b_d2_ff;
   div_tok_type          c_tok_ff;
   logic [G_W-1:0]       e_g_ff;
   logic [LR_W-1:0]      f_gl_ff;
   logic [COORD_W-1:0]   f_dfx_ff, f_dfy_ff, g_dfx_ff, g_dfy_ff;
   logic                 f_dirx_ff, f_diry_ff, g_dirx_ff, g_diry_ff;
   logic [LR_W+COORD_W-1:0] g_px_ff, g_py_ff;
   logic [WORD_W-1:0]    wr_data_ff;

   logic [DIV_W-1:0]     den;
   logic [GLP_W-1:0]     glp;
   logic [COORD_W-1:0]   dfx, dfy, nwx, nwy;
   logic [STP_W-1:0]     sumx, sumy;
   logic [COORD_W:0]     stx, sty;
   logic [EXP_IDX_W:0]   tok_vld;
   div_tok_type          tok [EXP_IDX_W+1];
   div_tok_type          c_tok_in;

   assign den = DIV_W'(r2) << SPAN_SH;

   // A: tag waits for the read data
   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
         b_vld_ff <= 1'b0;
      end else begin
         a_vld_ff <= issue.vld;
         b_vld_ff <= a_vld_ff;
      end
      a_idx_ff  <= issue.idx;
      a_dist_ff <= issue.ring_dist;
      b_idx_ff  <= a_idx_ff;
      b_wx_ff   <= rd_data[WORD_W-1:COORD_W];
      b_wy_ff   <= rd_data[COORD_W-1:0];
      b_d2_ff   <= a_dist_ff * a_dist_ff;
   end

   // C: build the dividend and flag indexes past the table
   always_comb begin
      c_tok_in      = '0;
      c_tok_in.vld  = b_vld_ff;
      c_tok_in.idx  = b_idx_ff;
      c_tok_in.wx   = b_wx_ff;
      c_tok_in.wy   = b_wy_ff;
      c_tok_in.over = DIV_W'(b_d2_ff) >= den;
      c_tok_in.rem  = DIV_W'(b_d2_ff) << EXP_IDX_W;
      c_tok_in.quot = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c_tok_ff.vld <= 1'b0;
      end else begin
         c_tok_ff.vld <= c_tok_in.vld;
      end
      c_tok_ff.idx  <= c_tok_in.idx;
      c_tok_ff.wx   <= c_tok_in.wx;
      c_tok_ff.wy   <= c_tok_in.wy;
      c_tok_ff.over <= c_tok_in.over;
      c_tok_ff.rem  <= c_tok_in.rem;
      c_tok_ff.quot <= c_tok_in.quot;
   end

   // chain of division cells, one quotient bit each
   assign tok[0] = c_tok_ff;
   for (genvar k = 0; k < EXP_IDX_W; k++) begin : g_cell
      som_ring_div_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .div_shift (den << (EXP_IDX_W - 1 - k)),
         .tok_in    (tok[k]),
         .tok_out   (tok[k+1])
      );
   end
   for (genvar k = 0; k <= EXP_IDX_W; k++) begin : g_vld
      assign tok_vld[k] = tok[k].vld;
   end

   // E: table lookup
   always_ff @(posedge clock) begin
      if (reset) begin
         e_vld_ff <= 1'b0;
      end else begin
         e_vld_ff <= tok[EXP_IDX_W].vld;
      end
      e_idx_ff <= tok[EXP_IDX_W].idx;
      e_wx_ff  <= tok[EXP_IDX_W].wx;
      e_wy_ff  <= tok[EXP_IDX_W].wy;
      e_g_ff   <= tok[EXP_IDX_W].over ? '0 : GAUSS_TAB[tok[EXP_IDX_W].quot];
   end

   // F: gain times learning rate, distances to the point
   assign glp = GLP_W'(e_g_ff) * GLP_W'(lr) + GLP_W'(1 << 15);
   assign dfx = (px >= e_wx_ff) ? px - e_wx_ff : e_wx_ff - px;
   assign dfy = (py >= e_wy_ff) ? py - e_wy_ff : e_wy_ff - py;

   always_ff @(posedge clock) begin
      if (reset) begin
         f_vld_ff <= 1'b0;
      end else begin
         f_vld_ff <= e_vld_ff;
      end
      f_idx_ff  <= e_idx_ff;
      f_wx_ff   <= e_wx_ff;
      f_wy_ff   <= e_wy_ff;
      f_gl_ff   <= glp[LR_W+15:16];
      f_dfx_ff  <= dfx;
      f_dfy_ff  <= dfy;
      f_dirx_ff <= px >= e_wx_ff;
      f_diry_ff <= py >= e_wy_ff;
   end

   // G: step products
   always_ff @(posedge clock) begin
      if (reset) begin
         g_vld_ff <= 1'b0;
      end else begin
         g_vld_ff <= f_vld_ff;
      end
      g_idx_ff  <= f_idx_ff;
      g_wx_ff   <= f_wx_ff;
      g_wy_ff   <= f_wy_ff;
      g_dfx_ff  <= f_dfx_ff;
      g_dfy_ff  <= f_dfy_ff;
      g_dirx_ff <= f_dirx_ff;
      g_diry_ff <= f_diry_ff;
      g_px_ff   <= f_gl_ff * f_dfx_ff;
      g_py_ff   <= f_gl_ff * f_dfy_ff;
   end

   // H: round, clamp to the distance, move toward the point
   assign sumx = STP_W'(g_px_ff) + STP_W'(1 << 23);
   assign sumy = STP_W'(g_py_ff) + STP_W'(1 << 23);
   assign stx  = (sumx[STP_W-1:24] > (COORD_W+1)'(g_dfx_ff)) ?
                 (COORD_W+1)'(g_dfx_ff) : sumx[STP_W-1:24];
   assign sty  = (sumy[STP_W-1:24] > (COORD_W+1)'(g_dfy_ff)) ?
                 (COORD_W+1)'(g_dfy_ff) : sumy[STP_W-1:24];
   assign nwx  = g_dirx_ff ? g_wx_ff + stx[COORD_W-1:0] : g_wx_ff - stx[COORD_W-1:0];
   assign nwy  = g_diry_ff ? g_wy_ff + sty[COORD_W-1:0] : g_wy_ff - sty[COORD_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_en_ff <= 1'b0;
      end else begin
         wr_en_ff <= g_vld_ff;
      end
      wr_addr_ff <= g_idx_ff;
      wr_data_ff <= {nwx, nwy};
   end

   assign wr_en   = wr_en_ff;
   assign wr_addr = wr_addr_ff;
   assign wr_data = wr_data_ff;
   assign busy    = a_vld_ff | b_vld_ff | (|tok_vld) | e_vld_ff | f_vld_ff |
                    g_vld_ff | wr_en_ff;

endmodule
`default_nettype wire

>>> hw/rtl/som_ring_training_step_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// som_ring_training_step_unit
// Ring self-organizing map trainer: winner search and neighborhood update.
// ----------------------------------------------------------------------------
// Load: result in the next cycle; the next item can be taken in the next
//   cycle unless a register write holds busy.
// Train: one memory read port scans all N neurons twice (search, then
//   update through the division cell chain), then decay and report.
// Finished or limit-reached train: result in the next cycle.
// Reset: registers to defaults, run restarted; weights undefined until loaded.
// Results go out on rsp_valid for one cycle; the receiver cannot stall.
module som_ring_training_step_unit
   import som_ring_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   // command channel
   input  wire logic               start,
   output logic                    busy,
   input  wire logic               req_action,
   input  wire logic [IDX_W-1:0]   req_neuron_index,
   input  wire logic [COORD_W-1:0] req_point_x,
   input  wire logic [COORD_W-1:0] req_point_y,
   // result channel
   output logic                    rsp_valid,
   output logic      [IDX_W-1:0]   rsp_winner_index,
   output logic                    rsp_finished,
   // register port
   input  wire logic               psel,
   input  wire logic               penable,
   input  wire logic               pwrite,
   input  wire logic [3:0]         paddr,
   input  wire logic [31:0]        pwdata,
   output logic      [31:0]        prdata,
   output logic                    pready
);

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_SEARCH = 5'b00010,
      ST_UPDATE = 5'b00100,
      ST_DECAY  = 5'b01000,
      ST_REPORT = 5'b10000
   } state_type;

   state_type           state_ff, state_in;
   logic [CNT_W-1:0]    n_cfg_ff, n_cfg_in;
   logic [LR_W-1:0]     lr_start_ff, lr_start_in;
   logic [ITER_W-1:0]   limit_ff, limit_in;
   logic [LR_W-1:0]     lr_ff, lr_in;
   logic [RAD_W-1:0]    rad_ff, rad_in;
   logic [ITER_W-1:0]   iter_ff, iter_in;
   logic                done_ff, done_in;
   logic [COORD_W-1:0]  px_ff, px_in, py_ff, py_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [R_W-1:0]      r_ff, r_in;
   logic [R2_W-1:0]     r2_ff;
   logic [IDX_W-1:0]    win_ff, win_in;
   logic                rsp_vld_ff, rsp_vld_in, rsp_fin_ff, rsp_fin_in;
   logic [IDX_W-1:0]    rsp_win_ff, rsp_win_in;

   logic                accept, csr_wr, srch_clear, srch_busy, upd_busy;
   logic                mem_we, upd_we;
   logic [IDX_W-1:0]    mem_waddr, upd_waddr, srch_win, dd, ring_dist;
   logic [WORD_W-1:0]   mem_wdata, upd_wdata, rd_data;
   logic [CNT_W-1:0]    n_ring, alt;
   logic [31:0]         rq;
   logic [R_W-1:0]      rq_r;
   logic [63:0]         lr_prod, rad_prod;
   issue_type           srch_issue, upd_issue;

   assign accept = start && !busy;
   assign csr_wr = psel && penable && pwrite;
   assign n_ring = ring_size(n_cfg_ff);

   // register port read
   always_comb begin
      case (paddr[3:2])
         CSR_NEURONS: prdata = 32'(n_cfg_ff);
         CSR_LR:      prdata = 32'(lr_start_ff);
         CSR_LIMIT:   prdata = limit_ff;
         default:     prdata = '0;
      endcase
   end
   assign pready = 1'b1;

   // radius: floor(n / 10) by reciprocal, at least one
   assign rq   = 32'(rad_ff[RAD_W-1:16]) * 32'(REC10);
   assign rq_r = R_W'(rq >> REC10_SH);

   // ring distance from the issue counter to the winner
   assign dd   = (cnt_ff[IDX_W-1:0] >= win_ff) ? cnt_ff[IDX_W-1:0] - win_ff
                                               : win_ff - cnt_ff[IDX_W-1:0];
   assign alt  = n_ring - CNT_W'(dd);
   assign ring_dist = (alt < CNT_W'(dd)) ? alt[IDX_W-1:0] : dd;

   assign lr_prod  = 64'(lr_ff) * 64'(LR_DECAY);
   assign rad_prod = 64'(rad_ff) * 64'(N_DECAY);

   // sequencer
   always_comb begin
      state_in    = state_ff;
      n_cfg_in    = n_cfg_ff;
      lr_start_in = lr_start_ff;
      limit_in    = limit_ff;
      lr_in       = lr_ff;
      rad_in      = rad_ff;
      iter_in     = iter_ff;
      done_in     = done_ff;
      px_in       = px_ff;
      py_in       = py_ff;
      cnt_in      = cnt_ff;
      r_in        = r_ff;
      win_in      = win_ff;
      rsp_vld_in  = 1'b0;
      rsp_win_in  = '0;
      rsp_fin_in  = done_ff;
      srch_clear  = 1'b0;
      srch_issue  = '0;
      upd_issue   = '0;

      case (state_ff)
         ST_IDLE: begin
            if (csr_wr) begin
               // restart the run from the new register values
               case (paddr[3:2])
                  CSR_NEURONS: n_cfg_in    = pwdata[CNT_W-1:0];
                  CSR_LR:      lr_start_in = pwdata[LR_W-1:0];
                  CSR_LIMIT:   limit_in    = pwdata;
                  default:     ;
               endcase
               if (paddr[3:2] == CSR_NEURONS || paddr[3:2] == CSR_LR ||
                   paddr[3:2] == CSR_LIMIT) begin
                  lr_in   = lr_start_in;
                  rad_in  = RAD_W'(ring_size(n_cfg_in)) << 16;
                  iter_in = '0;
                  done_in = 1'b0;
               end
            end else if (accept) begin
               rsp_vld_in = 1'b1;
               if (req_action == ACT_TRAIN && !done_ff) begin
                  if (iter_ff >= limit_ff) begin
                     done_in    = 1'b1;
                     rsp_fin_in = 1'b1;
                  end else begin
                     rsp_vld_in = 1'b0;
                     px_in      = req_point_x;
                     py_in      = req_point_y;
                     cnt_in     = '0;
                     r_in       = (rq_r == '0) ? R_W'(1) : rq_r;
                     srch_clear = 1'b1;
                     state_in   = ST_SEARCH;
                  end
               end
            end
         end
         ST_SEARCH: begin
            if (cnt_ff < n_ring) begin
               srch_issue.vld = 1'b1;
               srch_issue.idx = cnt_ff[IDX_W-1:0];
               cnt_in         = cnt_ff + CNT_W'(1);
            end else if (!srch_busy) begin
               win_in   = srch_win;
               cnt_in   = '0;
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            if (cnt_ff < n_ring) begin
               upd_issue.vld       = 1'b1;
               upd_issue.idx       = cnt_ff[IDX_W-1:0];
               upd_issue.ring_dist = ring_dist;
               cnt_in              = cnt_ff + CNT_W'(1);
            end else if (!upd_busy) begin
               state_in = ST_DECAY;
            end
         end
         ST_DECAY: begin
            lr_in    = lr_prod[LR_W+31:32];
            rad_in   = rad_prod[RAD_W+31:32];
            iter_in  = iter_ff + ITER_W'(1);
            state_in = ST_REPORT;
         end
         ST_REPORT: begin
            done_in    = (rad_ff < ONE_Q16) || (iter_ff >= limit_ff);
            rsp_vld_in = 1'b1;
            rsp_win_in = win_ff;
            rsp_fin_in = done_in;
            state_in   = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         n_cfg_ff    <= NEURONS_RST;
         lr_start_ff <= LR_START_RST;
         limit_ff    <= LIMIT_RST;
         lr_ff       <= LR_START_RST;
         rad_ff      <= RAD_W'(NEURONS_RST) << 16;
         iter_ff     <= '0;
         done_ff     <= 1'b0;
         cnt_ff      <= '0;
         rsp_vld_ff  <= 1'b0;
      end else begin
         state_ff    <= state_in;
         n_cfg_ff    <= n_cfg_in;
         lr_start_ff <= lr_start_in;
         limit_ff    <= limit_in;
         lr_ff       <= lr_in;
         rad_ff      <= rad_in;
         iter_ff     <= iter_in;
         done_ff     <= done_in;
         cnt_ff      <= cnt_in;
         rsp_vld_ff  <= rsp_vld_in;
      end
      px_ff      <= px_in;
      py_ff      <= py_in;
      r_ff       <= r_in;
      r2_ff      <= r_ff * r_ff;
      win_ff     <= win_in;
      rsp_win_ff <= rsp_win_in;
      rsp_fin_ff <= rsp_fin_in;
   end

   // weight memory: loads write while idle, the update pass otherwise
   assign mem_we    = (accept && req_action == ACT_LOAD) || upd_we;
   assign mem_waddr = upd_we ? upd_waddr : req_neuron_index;
   assign mem_wdata = upd_we ? upd_wdata : {req_point_x, req_point_y};

   som_ring_wmem u_wmem (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_addr (cnt_ff[IDX_W-1:0]),
      .rd_data (rd_data)
   );

   som_ring_srch u_srch (
      .clock   (clock),
      .reset   (reset),
      .clear   (srch_clear),
      .issue   (srch_issue),
      .rd_data (rd_data),
      .px      (px_ff),
      .py      (py_ff),
      .winner  (srch_win),
      .busy    (srch_busy)
   );

   som_ring_upd u_upd (
      .clock   (clock),
      .reset   (reset),
      .issue   (upd_issue),
      .rd_data (rd_data),
      .r2      (r2_ff),
      .lr      (lr_ff),
      .px      (px_ff),
      .py      (py_ff),
      .wr_en   (upd_we),
      .wr_addr (upd_waddr),
      .wr_data (upd_wdata),
      .busy    (upd_busy)
   );

   // hold off commands while a training step runs or a register write lands
   assign busy             = (state_ff != ST_IDLE) || csr_wr;
   assign rsp_valid        = rsp_vld_ff;
   assign rsp_winner_index = rsp_win_ff;
   assign rsp_finished     = rsp_fin_ff;

   // a load answers in the next cycle with winner zero
   a_load_rsp: assert property (@(posedge clock) disable iff (reset)
      (accept && req_action == ACT_LOAD) |=> (rsp_valid && rsp_winner_index == '0))
      else $error("load result missing");

   // finished holds until a register write restarts the run
   a_done_hold: assert property (@(posedge clock) disable iff (reset)
      (done_ff && !csr_wr) |=> done_ff)
      else $error("finished flag dropped");

   // no result while a pass is running
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(state_ff == ST_SEARCH || state_ff == ST_UPDATE))
      else $error("result during a pass");

   // the winner lies on the ring
   a_win_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_UPDATE) |-> (CNT_W'(win_ff) < n_ring))
      else $error("winner outside the ring");

endmodule
`default_nettype wire
